// ===== rtl/morse_letter_keyer_assert.svh =====
// Assertion macros shared by the keyer RTL.
// No dependencies; clk_i and rst_ni must exist in the including module.
`ifndef MORSE_LETTER_KEYER_ASSERT_SVH
`define MORSE_LETTER_KEYER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define MLK_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("keyer assertion failed");
`define MLK_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("keyer implication failed");
`define MLK_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("keyer next-cycle check failed");
`else
`define MLK_ASSERT(lbl, prop)
`define MLK_ASSERT_IMP(lbl, ante, cons)
`define MLK_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/mlk_pkg.sv =====
// Shared types, constants and the letter code table for the Morse keyer.
// No dependencies.
`timescale 1ns / 1ps
package mlk_pkg;

  localparam int CODE_BITS = 16;
  localparam int DOT_W     = 10;
  localparam int HOLD_W    = 12;
  localparam int SYM_W     = 3;
  localparam int CHAR_W    = 8;
  localparam int RUN_W     = 3;

  localparam logic [DOT_W-1:0] DOT_TIME_RST = DOT_W'(200);
  localparam logic [7:0]       CHAR_SPACE   = 8'h20;

  typedef enum logic [SYM_W-1:0] {
    SYM_NONE    = 3'd0,
    SYM_DOT     = 3'd1,
    SYM_DASH    = 3'd2,
    SYM_SPACE   = 3'd3,
    SYM_NEWLINE = 3'd4
  } sym_e;

  typedef enum logic [1:0] {
    K_NONE,
    K_LETTER,
    K_SPACE,
    K_NEWLINE
  } kind_e;

  typedef struct packed {
    kind_e                kind;
    logic [CODE_BITS-1:0] pattern;
  } cmd_t;

  // 16-bit left-aligned patterns, 1 = lit dot time
  function automatic logic [15:0] letter_raw(input logic [4:0] idx);
    logic [15:0] p;
    case (idx)
      5'd0:    p = 16'hB800;
      5'd1:    p = 16'hEA80;
      5'd2:    p = 16'hEBA0;
      5'd3:    p = 16'hEA00;
      5'd4:    p = 16'h8000;
      5'd5:    p = 16'hAE80;
      5'd6:    p = 16'hEE80;
      5'd7:    p = 16'hAA00;
      5'd8:    p = 16'hA000;
      5'd9:    p = 16'hBBB8;
      5'd10:   p = 16'hEB80;
      5'd11:   p = 16'hBA80;
      5'd12:   p = 16'hEE00;
      5'd13:   p = 16'hE800;
      5'd14:   p = 16'hEEE0;
      5'd15:   p = 16'hBBA0;
      5'd16:   p = 16'hEEB8;
      5'd17:   p = 16'hBA00;
      5'd18:   p = 16'hA800;
      5'd19:   p = 16'hE000;
      5'd20:   p = 16'hAE00;
      5'd21:   p = 16'hAB80;
      5'd22:   p = 16'hBB80;
      5'd23:   p = 16'hEAE0;
      5'd24:   p = 16'hEBB8;
      5'd25:   p = 16'hEEA0;
      default: p = 16'h0000;
    endcase
    return p;
  endfunction

  // top CODE_BITS bits of the pattern, zero padded below
  function automatic logic [CODE_BITS-1:0] letter_pattern(input logic [4:0] idx);
    logic [CODE_BITS+15:0] wide;
    wide = {letter_raw(idx), {CODE_BITS{1'b0}}};
    return wide[CODE_BITS+15 -: CODE_BITS];
  endfunction

endpackage

// ===== rtl/morse_letter_keyer.sv =====
// Morse keyer top level: config register, byte decode and serial keyer.
// Depends on mlk_pkg, mlk_decode, mlk_keyer.
//
// Usage:
//   Input stream (s_axis_*): one item per byte; tdata = char_code, tuser =
//   action (1 = end of message, char_code ignored). Letters of either case
//   are keyed, a space byte yields a word gap, any other byte is dropped
//   without a result.
//   Output stream (m_axis_*): one item per lamp slot or symbol; tdata packs
//   led_on, hold_ms and symbol, tlast marks the final item of an input.
//   cfg_we_i/cfg_wdata_i load the dot time in ms; write only when idle.
//   Timing: an item is taken when the keyer is idle, then its results leave
//   one per cycle through the output register while the receiver is ready.
//   A letter gives a result per pattern bit (trailing zeros dropped), a
//   symbol-only result for its last lit run and a closing gap. The rate is
//   set by the shift register that walks the pattern one bit per cycle.
//   The next item is accepted as soon as the last result of the current one
//   sits in the output register, even if that result is still stalled.
//   A receiver stall freezes the keyer with the result held on tdata.
//   Reset empties the output register, idles the keyer, dot time = 200.
`timescale 1ns / 1ps
module morse_letter_keyer
  import mlk_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [DOT_W-1:0]  cfg_wdata_i,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [CHAR_W-1:0] s_axis_tdata_i,   // [7:0] char_code
  input  logic              s_axis_tuser_i,   // [0] action
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [15:0]       m_axis_tdata_o,   // [0] led_on, [12:1] hold_ms, [15:13] symbol
  output logic              m_axis_tlast_o    // last item of this input
);

  logic [DOT_W-1:0]  dot_time_q;
  cmd_t              cmd;
  logic              led;
  logic [HOLD_W-1:0] hold;
  sym_e              sym;

  // dot time register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_time_q <= DOT_TIME_RST;
    end else if (cfg_we_i) begin
      dot_time_q <= cfg_wdata_i;
    end
  end

  mlk_decode u_decode (
    .action_i (s_axis_tuser_i),
    .char_i   (s_axis_tdata_i),
    .cmd_o    (cmd)
  );

  mlk_keyer u_keyer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (s_axis_tvalid_i),
    .cmd_ready_o (s_axis_tready_o),
    .cmd_i       (cmd),
    .dot_time_i  (dot_time_q),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_led_o   (led),
    .out_hold_o  (hold),
    .out_sym_o   (sym),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {sym, hold, led};

endmodule

// ===== rtl/mlk_decode.sv =====
// Character decode: classifies an input byte and looks up its code pattern.
// Depends on mlk_pkg.
`timescale 1ns / 1ps
module mlk_decode
  import mlk_pkg::*;
(
  input  logic              action_i,
  input  logic [CHAR_W-1:0] char_i,
  output cmd_t              cmd_o
);

  logic       is_letter;
  logic [4:0] idx;

  // 'A'..'Z' and 'a'..'z' share ch[4:0] = 1..26 with ch[7:6] = 01
  assign is_letter = (char_i[7:6] == 2'b01) && (char_i[4:0] != 5'd0) &&
                     (char_i[4:0] <= 5'd26);
  assign idx       = char_i[4:0] - 5'd1;

  always_comb begin
    cmd_o.pattern = letter_pattern(idx);
    if (action_i) begin
      cmd_o.kind = K_NEWLINE;
    end else if (char_i == CHAR_SPACE) begin
      cmd_o.kind = K_SPACE;
    end else if (is_letter) begin
      cmd_o.kind = K_LETTER;
    end else begin
      cmd_o.kind = K_NONE;
    end
  end

endmodule

// ===== rtl/mlk_keyer.sv =====
// Bit-serial sequencer: while not stalled, shifts the pattern out one
// slot per cycle into the result register. Uses mlk_pkg, assert header.
`timescale 1ns / 1ps
`include "morse_letter_keyer_assert.svh"
module mlk_keyer
  import mlk_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  cmd_t              cmd_i,
  input  logic [DOT_W-1:0]  dot_time_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic              out_led_o,
  output logic [HOLD_W-1:0] out_hold_o,
  output sym_e              out_sym_o,
  output logic              out_last_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_BITS,
    S_CLOSE,
    S_SPACE,
    S_NL
  } state_e;

  state_e               state_q;
  logic [CODE_BITS-1:0] sr_q;
  logic [RUN_W-1:0]     run_q;
  logic [1:0]           spc_q;
  logic                 out_valid_q;
  logic                 out_led_q;
  logic [HOLD_W-1:0]    out_hold_q;
  sym_e                 out_sym_q;
  logic                 out_last_q;

  logic              accept;
  logic              emit_ok;
  logic              load;
  logic [HOLD_W-1:0] hold1;
  logic [HOLD_W-1:0] hold3;
  logic [HOLD_W-1:0] hold4;
  sym_e              run_sym;
  logic              sr_empty;

  assign cmd_ready_o = (state_q == S_IDLE);
  assign accept      = cmd_valid_i && cmd_ready_o;
  assign emit_ok     = !out_valid_q || out_ready_i;
  assign load        = (state_q != S_IDLE) && emit_ok;
  assign sr_empty    = (sr_q == '0);

  assign hold1 = HOLD_W'(dot_time_i);
  assign hold3 = HOLD_W'({dot_time_i, 1'b0}) + HOLD_W'(dot_time_i);
  assign hold4 = HOLD_W'({dot_time_i, 2'b00});

  always_comb begin
    case (run_q)
      RUN_W'(1): run_sym = SYM_DOT;
      RUN_W'(3): run_sym = SYM_DASH;
      default:   run_sym = SYM_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      run_q       <= '0;
      spc_q       <= '0;
      sr_q        <= '0;
      out_led_q   <= 1'b0;
      out_hold_q  <= '0;
      out_sym_q   <= SYM_NONE;
      out_last_q  <= 1'b0;
    end else begin
      if (!load && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            sr_q  <= cmd_i.pattern;
            run_q <= '0;
            spc_q <= '0;
            case (cmd_i.kind)
              K_LETTER:  state_q <= S_BITS;
              K_SPACE:   state_q <= S_SPACE;
              K_NEWLINE: state_q <= S_NL;
              default:   state_q <= S_IDLE;
            endcase
          end
        end
        S_BITS: begin
          if (emit_ok) begin
            out_valid_q <= 1'b1;
            if (!sr_empty) begin
              sr_q       <= {sr_q[CODE_BITS-2:0], 1'b0};
              out_led_q  <= sr_q[CODE_BITS-1];
              out_hold_q <= hold1;
              out_last_q <= 1'b0;
              if (sr_q[CODE_BITS-1]) begin
                out_sym_q <= SYM_NONE;
                if (run_q != RUN_W'(4)) begin
                  run_q <= run_q + RUN_W'(1);
                end
              end else begin
                out_sym_q <= run_sym;
                run_q     <= '0;
              end
            end else if (run_sym != SYM_NONE) begin
              // trailing lit run gets a symbol-only result
              out_led_q  <= 1'b0;
              out_hold_q <= '0;
              out_sym_q  <= run_sym;
              out_last_q <= 1'b0;
              state_q    <= S_CLOSE;
            end else begin
              out_led_q  <= 1'b0;
              out_hold_q <= hold3;
              out_sym_q  <= SYM_SPACE;
              out_last_q <= 1'b1;
              state_q    <= S_IDLE;
            end
          end
        end
        S_CLOSE: begin
          if (emit_ok) begin
            out_valid_q <= 1'b1;
            out_led_q   <= 1'b0;
            out_hold_q  <= hold3;
            out_sym_q   <= SYM_SPACE;
            out_last_q  <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        S_SPACE: begin
          if (emit_ok) begin
            out_valid_q <= 1'b1;
            out_led_q   <= 1'b0;
            out_hold_q  <= (spc_q == 2'd0) ? hold4 : '0;
            out_sym_q   <= SYM_SPACE;
            out_last_q  <= (spc_q == 2'd2);
            spc_q       <= spc_q + 2'd1;
            if (spc_q == 2'd2) begin
              state_q <= S_IDLE;
            end
          end
        end
        S_NL: begin
          if (emit_ok) begin
            out_valid_q <= 1'b1;
            out_led_q   <= 1'b0;
            out_hold_q  <= '0;
            out_sym_q   <= SYM_NEWLINE;
            out_last_q  <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_led_o   = out_led_q;
  assign out_hold_o  = out_hold_q;
  assign out_sym_o   = out_sym_q;
  assign out_last_o  = out_last_q;

  `MLK_ASSERT_NXT(a_letter_starts, accept && (cmd_i.kind == K_LETTER), state_q == S_BITS)
  `MLK_ASSERT_IMP(a_run_bounded, state_q == S_BITS, run_q <= RUN_W'(3))
  `MLK_ASSERT_IMP(a_done_has_last, $fell(state_q != S_IDLE), out_valid_q && out_last_q)
  `MLK_ASSERT_NXT(a_last_ends, load && (state_q == S_NL), state_q == S_IDLE)

endmodule
